>>> src/ptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared widths, register indexes and types of the pressure and temperature
// compensation core.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int TEMP_W  = 18;
  localparam int PRES_W  = 23;
  localparam int DT_W    = 25;
  localparam int PROD_W  = 42;
  localparam int OFF_W   = 35;
  localparam int SENS_W  = 34;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_SENS          = 3'd0;
  localparam logic [2:0] REG_OFFSET        = 3'd1;
  localparam logic [2:0] REG_SENS_TEMPCO   = 3'd2;
  localparam logic [2:0] REG_OFFSET_TEMPCO = 3'd3;
  localparam logic [2:0] REG_REF_TEMP      = 3'd4;
  localparam logic [2:0] REG_TEMP_SLOPE    = 3'd5;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] offset;
    logic [COEF_W-1:0] sens_tempco;
    logic [COEF_W-1:0] offset_tempco;
    logic [COEF_W-1:0] ref_temp;
    logic [COEF_W-1:0] temp_slope;
  } ptc_coef_t;

  // Item handed from the temperature half to the pressure half.
  typedef struct packed {
    logic [RAW_W-1:0]         raw_pressure;
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
  } ptc_mid_t;

endpackage

>>> src/ptc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_sample_if / ptc_result_if
// Valid/ready channels for the raw readings and the compensated results.
// ----------------------------------------------------------------------------
interface ptc_sample_if;
  import ptc_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface ptc_result_if;
  import ptc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_centideg;
  logic signed [PRES_W-1:0] pressure_centimbar;

  modport source (output valid, output temp_centideg, output pressure_centimbar, input ready);
  modport sink   (input valid, input temp_centideg, input pressure_centimbar, output ready);
endinterface

>>> src/pressure_temperature_compensation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_core
// First-order barometric sensor compensation: raw pressure and temperature
// in, temperature in 0.01 degC and pressure in 0.01 mbar out.
// ----------------------------------------------------------------------------
// The core takes one pair of raw 24-bit readings per transfer on the sample
// channel and returns one result per pair on the result channel, in order.
// It is a seven-stage pipeline that accepts a new pair in every cycle unless
// a stall from the result side has filled it, so the sustained rate is one
// item per clock while the result side is ready.
// Stage one forms the temperature difference, stage two the three products
// of that difference with the calibration words, stage three the
// temperature and the offset and sensitivity terms. Raw pressure times
// sensitivity is wider than one multiplier, so stage four forms it as two
// partial products and stage five adds them; stage six scales and removes
// the offset, stage seven scales again and saturates into the output
// register. Each stage holds a valid bit and stalls only when the stage
// after it is full and stalled, so bubbles are squeezed out and a waiting
// result does not block new samples until the pipeline is full. All
// power-of-two divisions round toward zero. The six calibration words sit
// on an APB port at byte addresses 0, 4, ... 20, reset to zero, and are to
// be written only while no sample is in flight.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_core
  import ptc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  ptc_sample_if.sink        sample,
  ptc_result_if.source      result
);

  ptc_coef_t coef;
  ptc_mid_t  mid;
  logic      mid_valid;
  logic      mid_ready;

  // Calibration word storage.
  ptc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  // Temperature, offset and sensitivity.
  ptc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .sample    (sample),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid)
  );

  // Pressure product, scaling and saturation.
  ptc_press u_press (
    .clk       (clk),
    .rst       (rst),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid),
    .result    (result)
  );

endmodule

>>> src/ptc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_regs
// APB register file holding the six calibration words.
// ----------------------------------------------------------------------------
module ptc_regs
  import ptc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output ptc_coef_t         coef
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SENS:          coef.sens          <= pwdata[COEF_W-1:0];
        REG_OFFSET:        coef.offset        <= pwdata[COEF_W-1:0];
        REG_SENS_TEMPCO:   coef.sens_tempco   <= pwdata[COEF_W-1:0];
        REG_OFFSET_TEMPCO: coef.offset_tempco <= pwdata[COEF_W-1:0];
        REG_REF_TEMP:      coef.ref_temp      <= pwdata[COEF_W-1:0];
        REG_TEMP_SLOPE:    coef.temp_slope    <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SENS:          prdata = {16'd0, coef.sens};
      REG_OFFSET:        prdata = {16'd0, coef.offset};
      REG_SENS_TEMPCO:   prdata = {16'd0, coef.sens_tempco};
      REG_OFFSET_TEMPCO: prdata = {16'd0, coef.offset_tempco};
      REG_REF_TEMP:      prdata = {16'd0, coef.ref_temp};
      REG_TEMP_SLOPE:    prdata = {16'd0, coef.temp_slope};
      default:           prdata = '0;
    endcase
  end

endmodule

>>> src/ptc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_front
// Stages one to three: temperature difference, the three coefficient
// products, then temperature, offset and sensitivity.
// ----------------------------------------------------------------------------
module ptc_front
  import ptc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ptc_coef_t        coef,
  ptc_sample_if.sink       sample,
  output logic             mid_valid,
  input  logic             mid_ready,
  output ptc_mid_t         mid
);

  // Stage 1 registers.
  logic                     v1;
  logic [RAW_W-1:0]         d1_s1;
  logic signed [DT_W-1:0]   dt1;
  // Stage 2 registers.
  logic                     v2;
  logic [RAW_W-1:0]         d1_s2;
  logic signed [PROD_W-1:0] pt2;
  logic signed [PROD_W-1:0] po2;
  logic signed [PROD_W-1:0] ps2;
  // Stage 3 registers.
  logic                     v3;

  logic rdy1, rdy2, rdy3;

  logic signed [DT_W-1:0]   dt_next;
  logic signed [PROD_W-1:0] pt_sum, po_sum, ps_sum;
  logic signed [19:0]       temp_full;
  logic signed [TEMP_W-1:0] temp_next;
  logic signed [OFF_W-1:0]  off_next;
  logic signed [SENS_W-1:0] sens_next;

  assign rdy3 = ~v3 | mid_ready;
  assign rdy2 = ~v2 | rdy3;
  assign rdy1 = ~v1 | rdy2;
  assign sample.ready = rdy1;
  assign mid_valid    = v3;

  assign dt_next = $signed({1'b0, sample.raw_temperature})
                 - $signed({1'b0, coef.ref_temp, 8'd0});

  // Division by a power of two rounds toward zero: add (2^k - 1) to
  // negative values before the arithmetic shift.
  assign pt_sum = pt2 + $signed({19'd0, {23{pt2[PROD_W-1]}}});
  assign po_sum = po2 + $signed({35'd0, {7{po2[PROD_W-1]}}});
  assign ps_sum = ps2 + $signed({34'd0, {8{ps2[PROD_W-1]}}});

  assign temp_full = $signed({pt_sum[PROD_W-1], pt_sum[PROD_W-1:23]}) + 20'sd2000;
  assign off_next  = $signed({3'd0, coef.offset, 16'd0}) + $signed(po_sum[PROD_W-1:7]);
  assign sens_next = $signed({3'd0, coef.sens, 15'd0}) + $signed(ps_sum[PROD_W-1:8]);

  always_comb begin
    if (temp_full > 20'sd131071) begin
      temp_next = 18'sd131071;
    end else if (temp_full < -20'sd131072) begin
      temp_next = {1'b1, {(TEMP_W-1){1'b0}}};
    end else begin
      temp_next = temp_full[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= sample.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && sample.valid) begin
      d1_s1 <= sample.raw_pressure;
      dt1   <= dt_next;
    end
    if (rdy2 && v1) begin
      d1_s2 <= d1_s1;
      pt2   <= dt1 * $signed({1'b0, coef.temp_slope});
      po2   <= dt1 * $signed({1'b0, coef.offset_tempco});
      ps2   <= dt1 * $signed({1'b0, coef.sens_tempco});
    end
    if (rdy3 && v2) begin
      mid.raw_pressure <= d1_s2;
      mid.temp         <= temp_next;
      mid.off          <= off_next;
      mid.sens         <= sens_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> v1)
    else $error("accepted sample did not reach stage one");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v1 && !rdy2) |=> (v1 && $stable(dt1) && $stable(d1_s1)))
    else $error("stalled stage one lost its item");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (v2 && rdy3) |=> v3)
    else $error("stage two item not moved to stage three");
`endif

endmodule

>>> src/ptc_press.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_press
// Stages four to seven: raw pressure times sensitivity as two partial
// products, their sum, scaling less offset, final scaling and saturation.
// ----------------------------------------------------------------------------
module ptc_press
  import ptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        mid_valid,
  output logic        mid_ready,
  input  ptc_mid_t    mid,
  ptc_result_if.source result
);

  logic v4, v5, v6, v7;
  logic rdy4, rdy5, rdy6, rdy7;

  logic [40:0]              lo4;
  logic signed [41:0]       hi4;
  logic signed [OFF_W-1:0]  off4, off5;
  logic signed [TEMP_W-1:0] temp4, temp5, temp6;
  logic signed [58:0]       prod5;
  logic signed [38:0]       diff6;

  logic signed [58:0]       prod_sum;
  logic signed [38:0]       diff_next;
  logic signed [38:0]       diff_sum;
  logic signed [23:0]       pq;
  logic signed [PRES_W-1:0] pres_next;

  assign rdy7 = ~v7 | result.ready;
  assign rdy6 = ~v6 | rdy7;
  assign rdy5 = ~v5 | rdy6;
  assign rdy4 = ~v4 | rdy5;
  assign mid_ready    = rdy4;
  assign result.valid = v7;

  assign prod_sum  = prod5 + $signed({38'd0, {21{prod5[58]}}});
  assign diff_next = $signed({prod_sum[58], prod_sum[58:21]})
                   - $signed({{4{off5[OFF_W-1]}}, off5});
  assign diff_sum  = diff6 + $signed({24'd0, {15{diff6[38]}}});
  assign pq        = diff_sum[38:15];

  always_comb begin
    if (pq > 24'sd4194303) begin
      pres_next = 23'sd4194303;
    end else if (pq < -24'sd4194304) begin
      pres_next = {1'b1, {(PRES_W-1){1'b0}}};
    end else begin
      pres_next = pq[PRES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy4) v4 <= mid_valid;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
      if (rdy7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && mid_valid) begin
      lo4   <= mid.raw_pressure * mid.sens[16:0];
      hi4   <= $signed({1'b0, mid.raw_pressure}) * $signed(mid.sens[SENS_W-1:17]);
      off4  <= mid.off;
      temp4 <= mid.temp;
    end
    if (rdy5 && v4) begin
      prod5 <= $signed({hi4, 17'd0}) + $signed({18'd0, lo4});
      off5  <= off4;
      temp5 <= temp4;
    end
    if (rdy6 && v5) begin
      diff6 <= diff_next;
      temp6 <= temp5;
    end
    if (rdy7 && v6) begin
      result.temp_centideg      <= temp6;
      result.pressure_centimbar <= pres_next;
    end
  end

`ifndef SYNTHESIS
  a_out_after_reset: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");
  a_take_mid: assert property (@(posedge clk) disable iff (rst)
    (mid_valid && mid_ready) |=> v4)
    else $error("handoff item not captured in stage four");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v6 && !rdy7) |=> (v6 && $stable(diff6)))
    else $error("stalled stage six lost its item");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for pressure_temperature_compensation_core. Raw
// pressure and temperature pairs go in on the sample channel under random
// source gaps and result-side stalls. An in-house model of the first-order
// compensation predicts each result, and every result transfer is checked
// field by field against the oldest prediction. The calibration words are
// loaded over APB between phases: reset values, a typical factory set, a
// saturating extreme set and several random sets.
// ----------------------------------------------------------------------------
module tb;
  import ptc_pkg::*;

  // Register indexes past the last calibration word. Writes there must be
  // ignored by the core, so the model ignores them too.
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  // Scale factors of the first-order compensation formulas.
  localparam longint TEMP_ZERO_POINT = 2000;
  localparam longint REF_TEMP_SCALE  = 256;
  localparam longint TEMP_SCALE      = 8388608;
  localparam longint OFFSET_SCALE    = 65536;
  localparam longint OFF_TC_SCALE    = 128;
  localparam longint SENS_BASE_SCALE = 32768;
  localparam longint SENS_TC_SCALE   = 256;
  localparam longint SENS_SCALE      = 2097152;
  localparam longint PRES_SCALE      = 32768;

  // Saturation limits of the two result fields.
  localparam longint TEMP_LO = -131072;
  localparam longint TEMP_HI = 131071;
  localparam longint PRES_LO = -4194304;
  localparam longint PRES_HI = 4194303;

  localparam logic [RAW_W-1:0] RAW_MAX = '1;
  localparam int RAW_TOP           = 16777215;
  localparam int DRAIN_CYCLES      = 16;     // well past the depth of the seven-stage pipeline
  localparam int IDLE_GUARD        = 20000;  // cycles allowed for a phase to drain
  localparam int RANDOM_PHASES     = 6;
  localparam int ITEMS_PER_PHASE   = 85;
  localparam int RESET_PHASE_ITEMS = 40;
  localparam int REPORT_CAP        = 100;

  typedef struct packed {
    logic [RAW_W-1:0] pressure;
    logic [RAW_W-1:0] temperature;
  } raw_pair_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic signed [PRES_W-1:0] pres;
  } comp_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ptc_sample_if sample_ch();
  ptc_result_if result_ch();

  pressure_temperature_compensation_core uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (sample_ch),
    .result  (result_ch)
  );

  // Shadow copy of the calibration words, updated as each APB write lands.
  ptc_coef_t coef_model = '0;

  // Readings waiting to be offered, and predictions waiting for results.
  raw_pair_t    pending_readings[$];
  comp_result_t awaited_results[$];

  // When set, the matching side never idles, which gives long back-to-back
  // stretches through the pipeline.
  bit src_calm = 1'b0;
  bit snk_calm = 1'b0;

  int src_gap        = 0;
  int snk_stall      = 0;
  int accepted_count = 0;
  int checked_count  = 0;
  int settings_count = 0;
  int fail_count     = 0;

  raw_pair_t    offered_pair;
  raw_pair_t    taken_pair;
  comp_result_t oldest_result;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction. All arithmetic is in 64-bit signed integers, where SystemVerilog
  // division truncates toward zero just as the datasheet formulas require. The
  // largest intermediate, raw pressure times sensitivity, stays below 2^58.
  // --------------------------------------------------------------------------
  function automatic comp_result_t compensate(raw_pair_t pair, ptc_coef_t c);
    longint d1;
    longint d2;
    longint dt;
    longint t;
    longint off;
    longint sens;
    longint p;
    comp_result_t r;
    d1   = longint'({40'd0, pair.pressure});
    d2   = longint'({40'd0, pair.temperature});
    dt   = d2 - longint'({48'd0, c.ref_temp}) * REF_TEMP_SCALE;
    t    = TEMP_ZERO_POINT + (dt * longint'({48'd0, c.temp_slope})) / TEMP_SCALE;
    off  = longint'({48'd0, c.offset}) * OFFSET_SCALE
         + (longint'({48'd0, c.offset_tempco}) * dt) / OFF_TC_SCALE;
    sens = longint'({48'd0, c.sens}) * SENS_BASE_SCALE
         + (longint'({48'd0, c.sens_tempco}) * dt) / SENS_TC_SCALE;
    p    = ((d1 * sens) / SENS_SCALE - off) / PRES_SCALE;
    // Both fields saturate rather than wrap.
    if (t < TEMP_LO) t = TEMP_LO;
    if (t > TEMP_HI) t = TEMP_HI;
    if (p < PRES_LO) p = PRES_LO;
    if (p > PRES_HI) p = PRES_HI;
    r.temp = t[TEMP_W-1:0];
    r.pres = p[PRES_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= REPORT_CAP) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Sample driver. A new pair is offered once the previous one has been taken
  // and the random gap after it has run out. The prediction is formed at the
  // transfer itself, from the calibration words in force at that moment.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        taken_pair = {sample_ch.raw_pressure, sample_ch.raw_temperature};
        awaited_results.push_back(compensate(taken_pair, coef_model));
        accepted_count++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          sample_ch.valid <= 1'b0;
        end else if (pending_readings.size() != 0) begin
          offered_pair = pending_readings.pop_front();
          sample_ch.raw_pressure    <= offered_pair.pressure;
          sample_ch.raw_temperature <= offered_pair.temperature;
          sample_ch.valid           <= 1'b1;
          src_gap = pick_gap(src_calm);
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Every result transfer is matched to the oldest prediction;
  // ready is dropped for random stretches to push back into the pipeline.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      snk_stall = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result transfer with no sample outstanding");
        end else begin
          oldest_result = awaited_results.pop_front();
          checked_count++;
          if (result_ch.temp_centideg !== oldest_result.temp) begin
            report_mismatch($sformatf("result %0d temp_centideg got %0d want %0d",
              checked_count, result_ch.temp_centideg, oldest_result.temp));
          end
          if (result_ch.pressure_centimbar !== oldest_result.pres) begin
            report_mismatch($sformatf("result %0d pressure_centimbar got %0d want %0d",
              checked_count, result_ch.pressure_centimbar, oldest_result.pres));
          end
        end
      end
      if (snk_stall > 0) begin
        snk_stall--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        snk_stall = pick_gap(snk_calm);
      end
    end
  end

  // --------------------------------------------------------------------------
  // APB write: a setup cycle, then an access cycle held until pready. The
  // shadow copy keeps only the low sixteen bits, and indexes past the last
  // calibration word leave it untouched.
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SENS:          coef_model.sens          = data[COEF_W-1:0];
      REG_OFFSET:        coef_model.offset        = data[COEF_W-1:0];
      REG_SENS_TEMPCO:   coef_model.sens_tempco   = data[COEF_W-1:0];
      REG_OFFSET_TEMPCO: coef_model.offset_tempco = data[COEF_W-1:0];
      REG_REF_TEMP:      coef_model.ref_temp      = data[COEF_W-1:0];
      REG_TEMP_SLOPE:    coef_model.temp_slope    = data[COEF_W-1:0];
      default: ;
    endcase
  endtask

  // Loads a full set of calibration words. In about half the loads the writes carry
  // junk in the upper half of the data bus, and each load also pokes both spare indexes.
  task automatic load_coefs(input ptc_coef_t c);
    logic [DATA_W-1:0] junk;
    junk = $urandom;
    if ($urandom_range(0, 1) == 0) junk[DATA_W-1:COEF_W] = '0;
    junk[COEF_W-1:0] = '0;
    write_reg(REG_SENS,          junk | c.sens);
    write_reg(REG_OFFSET,        junk | c.offset);
    write_reg(REG_SENS_TEMPCO,   junk | c.sens_tempco);
    write_reg(REG_OFFSET_TEMPCO, junk | c.offset_tempco);
    write_reg(REG_REF_TEMP,      junk | c.ref_temp);
    write_reg(REG_TEMP_SLOPE,    junk | c.temp_slope);
    write_reg(REG_SPARE_A,       $urandom);
    write_reg(REG_SPARE_B,       $urandom);
    settings_count++;
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      default: return r[COEF_W-1:0];
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return RAW_MAX;
      default: return r[RAW_W-1:0];
    endcase
  endfunction

  // A raw temperature a given distance from the reference point, clamped to
  // the field. Real sensors sit close to it, so small differences dominate.
  function automatic logic [RAW_W-1:0] near_ref(input int delta);
    int v;
    v = int'({16'd0, coef_model.ref_temp}) * int'(REF_TEMP_SCALE) + delta;
    if (v < 0) v = 0;
    if (v > RAW_TOP) v = RAW_TOP;
    return v[RAW_W-1:0];
  endfunction

  function automatic void push_pair(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
    pending_readings.push_back({p, t});
  endfunction

  // Field extremes, alternating bit patterns, the sign boundary, and pairs with
  // the temperature right at and just around the reference point.
  task automatic queue_directed();
    @(negedge clk);
    push_pair('0, '0);
    push_pair(RAW_MAX, RAW_MAX);
    push_pair('0, RAW_MAX);
    push_pair(RAW_MAX, '0);
    push_pair(24'h555555, 24'hAAAAAA);
    push_pair(24'hAAAAAA, 24'h555555);
    push_pair(24'h800000, 24'h7FFFFF);
    push_pair(24'h7FFFFF, 24'h800000);
    push_pair(RAW_MAX, near_ref(0));
    push_pair(24'h400000, near_ref(1));
    push_pair(24'h400000, near_ref(-1));
    push_pair(24'hC00000, near_ref(-256));
  endtask

  task automatic queue_random(input int count);
    @(negedge clk);
    repeat (count) begin
      if ($urandom_range(0, 9) < 3) begin
        push_pair(pick_raw(), near_ref($urandom_range(0, 20000) - 10000));
      end else begin
        push_pair(pick_raw(), pick_raw());
      end
    end
  endtask

  // Polls on the falling edge so the queues are never read mid-update, then
  // lets the pipeline settle. The guard keeps a lost result from hanging here.
  task automatic wait_idle();
    int guard;
    guard = 0;
    @(negedge clk);
    while ((pending_readings.size() != 0 || sample_ch.valid || awaited_results.size() != 0)
           && guard < IDLE_GUARD) begin
      @(negedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Run sequence.
  // --------------------------------------------------------------------------
  initial begin
    ptc_coef_t typical;
    ptc_coef_t extreme;
    ptc_coef_t drawn;
    int ph;

    // Every input known from time zero.
    psel                      = 1'b0;
    penable                   = 1'b0;
    pwrite                    = 1'b0;
    paddr                     = '0;
    pwdata                    = '0;
    sample_ch.valid           = 1'b0;
    sample_ch.raw_pressure    = '0;
    sample_ch.raw_temperature = '0;
    result_ch.ready           = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // The calibration words are all zero out of reset; run a batch on them
    // before anything is written.
    settings_count++;
    queue_random(RESET_PHASE_ITEMS);
    wait_idle();

    // A plausible factory calibration, with the directed corner pairs.
    typical = '{sens: 16'd46372, offset: 16'd43981, sens_tempco: 16'd29059,
                offset_tempco: 16'd27842, ref_temp: 16'd31553, temp_slope: 16'd28165};
    load_coefs(typical);
    queue_directed();
    wait_idle();

    // Every word at full scale except a zero reference point: with the raw
    // temperature at full scale the temperature runs past its range and has
    // to saturate.
    extreme = '1;
    extreme.ref_temp = '0;
    load_coefs(extreme);
    queue_directed();
    wait_idle();

    // Random calibrations. The first runs with no idling on either side, the
    // next two idle only one side each, and the last uses all-ones words.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      drawn = '{sens: pick_coef(), offset: pick_coef(), sens_tempco: pick_coef(),
                offset_tempco: pick_coef(), ref_temp: pick_coef(), temp_slope: pick_coef()};
      if (ph == RANDOM_PHASES - 1) drawn = '1;
      src_calm = (ph == 0) || (ph == 1);
      snk_calm = (ph == 0) || (ph == 2);
      load_coefs(drawn);
      queue_random(ITEMS_PER_PHASE);
      wait_idle();
    end

    if (awaited_results.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never arrived",
        awaited_results.size()));
    end

    $display("Covered %0d sample transfers under %0d calibration settings.",
      accepted_count, settings_count);
    $display("Compared %0d results, %0d field mismatches.", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
